@@ rtl/i2cm16_pkg.sv @@
// Package for the 16-bit register I2C master: beat types, op codes and sequencer states.
package i2cm16_pkg;

    // Op codes carried in the input beat
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration reset value: ticks per SCL phase
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd15;

    // Bits per byte before the acknowledge slot
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Byte steps of a transaction
    localparam logic [2:0] STEP_ADDR  = 3'd0;
    localparam logic [2:0] STEP_SUB   = 3'd1;
    localparam logic [2:0] STEP_SEC   = 3'd2;
    localparam logic [2:0] STEP_THIRD = 3'd3;
    localparam logic [2:0] STEP_LAST  = 3'd4;

    // Bus sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_HI,
        ST_START_LO,
        ST_BIT_LO,
        ST_BIT_HI,
        ST_RS_LO,
        ST_STOP_LO,
        ST_STOP_HI,
        ST_STOP_REL
    } t_seq_state;

    // Input beat: one timing tick
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  dev_addr;
        logic [7:0]  reg_index;
        logic [15:0] wr_data;
        logic        sda_sample;
    } t_in_item;

    // Output beat: bus levels and status for one tick
    typedef struct packed {
        logic        scl_drive;
        logic        sda_drive;
        logic        busy_res;
        logic        done_res;
        logic        nack_error;
        logic [15:0] rd_data;
    } t_out_item;

endpackage

@@ rtl/i2c_master_reg16_access_top.sv @@
// Top level of the I2C master for 16-bit register write and read transactions.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data): one beat per timing tick.
//   op = write or read starts a transaction when the sequencer is idle; otherwise
//   the op is ignored and the beat just advances time. sda_sample is the SDA
//   level seen on that tick.
//   Output channel (o_out_valid / i_out_ready / o_out_data): exactly one beat per
//   input beat, carrying the SCL/SDA open-drain levels, busy, a one-beat done
//   pulse, the NACK flag and the read word.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): sets the number of
//   ticks per SCL low or high phase (zero acts as one). Write it only when idle.
// Latency and throughput: a result is registered when its input beat is taken;
//   one beat per cycle unless stalled, limited by the single sequencer state update.
// Stall: the result register holds while i_out_ready is low and o_in_ready
//   drops with it, so no beat is lost; a taken result frees room the same cycle.
// Reset: synchronous, active low; sequencer idles, phase length goes to 15,
//   output register empty.
module i2c_master_reg16_access_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2cm16_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cm16_pkg::t_out_item o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [15:0]           i_cfg_data
);
    import i2cm16_pkg::*;

    // Configuration and sequencer state
    logic [15:0] r_half;
    t_seq_state  r_state,   n_state;
    logic [15:0] r_phase,   n_phase;
    logic [3:0]  r_bit,     n_bit;
    logic [2:0]  r_step,    n_step;
    logic [7:0]  r_shift,   n_shift;
    logic [7:0]  r_addr,    n_addr;
    logic [7:0]  r_reg,     n_reg;
    logic [15:0] r_data,    n_data;
    logic [15:0] r_rx,      n_rx;
    logic        r_ack,     n_ack;
    logic        r_is_read, n_is_read;

    // Result register
    t_out_item   r_out, n_out;
    logic        r_out_valid;
    logic        in_fire;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Byte to send at a given step
    function automatic logic [7:0] f_byte(input logic [2:0] step, input logic rd,
                                          input logic [7:0] addr, input logic [7:0] sub,
                                          input logic [15:0] data);
        logic [15:0] inv;
        inv = ~data;
        unique case (step)
            STEP_ADDR:  f_byte = addr;
            STEP_SUB:   f_byte = rd ? 8'd0 : sub;
            STEP_SEC:   f_byte = rd ? (addr + 8'd1) : inv[7:0];
            STEP_THIRD: f_byte = rd ? 8'd0 : inv[15:8];
            default:    f_byte = 8'd0;
        endcase
    endfunction

    // Next state and result for one tick
    always_comb begin
        t_seq_state  c_state;
        logic [15:0] c_phase;
        logic [3:0]  c_bit;
        logic [2:0]  c_step;
        logic [7:0]  c_shift;
        logic [15:0] c_rx;
        logic        c_ack;
        logic [16:0] ph_inc;
        logic [16:0] h_eff;
        logic        phase_end;
        logic        rcv;
        logic        lvl;
        logic        sda;
        logic        start_op;

        sda      = i_in_data.sda_sample;
        start_op = (r_state == ST_IDLE) &&
                   (i_in_data.op == OP_WRITE || i_in_data.op == OP_READ);

        n_addr    = r_addr;
        n_reg     = r_reg;
        n_data    = r_data;
        n_is_read = r_is_read;
        c_state   = r_state;
        c_phase   = r_phase;
        c_bit     = r_bit;
        c_step    = r_step;
        c_shift   = r_shift;
        c_rx      = r_rx;
        c_ack     = r_ack;

        // Latch a new transaction
        if (start_op) begin
            n_addr    = i_in_data.dev_addr;
            n_reg     = i_in_data.reg_index;
            n_data    = i_in_data.wr_data;
            n_is_read = (i_in_data.op == OP_READ);
            c_state   = ST_START_HI;
            c_phase   = 16'd0;
            c_bit     = 4'd0;
            c_step    = STEP_ADDR;
            c_shift   = 8'd0;
            c_rx      = 16'd0;
            c_ack     = 1'b1;
        end

        n_state = c_state;
        n_phase = c_phase;
        n_bit   = c_bit;
        n_step  = c_step;
        n_shift = c_shift;
        n_rx    = c_rx;
        n_ack   = c_ack;

        // SDA level for the current bit slot
        rcv = n_is_read && (c_step >= STEP_THIRD);
        if (c_bit < BITS_PER_BYTE) begin
            lvl = rcv ? 1'b1 : c_shift[7];
        end else if (rcv) begin
            lvl = (c_step != STEP_THIRD);
        end else begin
            lvl = 1'b1;
        end

        // Bus levels
        n_out.busy_res   = (c_state != ST_IDLE);
        n_out.done_res   = 1'b0;
        n_out.nack_error = 1'b0;
        n_out.rd_data    = 16'd0;
        unique case (c_state)
            ST_START_LO: begin n_out.scl_drive = 1'b1; n_out.sda_drive = 1'b0; end
            ST_BIT_LO:   begin n_out.scl_drive = 1'b0; n_out.sda_drive = lvl;  end
            ST_BIT_HI:   begin n_out.scl_drive = 1'b1; n_out.sda_drive = lvl;  end
            ST_RS_LO:    begin n_out.scl_drive = 1'b0; n_out.sda_drive = 1'b1; end
            ST_STOP_LO:  begin n_out.scl_drive = 1'b0; n_out.sda_drive = 1'b0; end
            ST_STOP_HI:  begin n_out.scl_drive = 1'b1; n_out.sda_drive = 1'b0; end
            default:     begin n_out.scl_drive = 1'b1; n_out.sda_drive = 1'b1; end
        endcase

        // Phase timer
        ph_inc    = {1'b0, c_phase} + 17'd1;
        h_eff     = (r_half == 16'd0) ? 17'd1 : {1'b0, r_half};
        phase_end = !(ph_inc < h_eff);

        if (c_state != ST_IDLE) begin
            if (!phase_end) begin
                n_phase = ph_inc[15:0];
            end else begin
                n_phase = 16'd0;
                unique case (c_state)
                    ST_START_HI: n_state = ST_START_LO;
                    ST_START_LO: begin
                        n_shift = f_byte(c_step, n_is_read, n_addr, n_reg, n_data);
                        n_bit   = 4'd0;
                        n_state = ST_BIT_LO;
                    end
                    ST_BIT_LO:   n_state = ST_BIT_HI;
                    ST_BIT_HI: begin
                        if (c_bit < BITS_PER_BYTE) begin
                            n_shift = {c_shift[6:0], rcv & sda};
                            n_bit   = c_bit + 4'd1;
                            n_state = ST_BIT_LO;
                        end else if (!rcv && sda) begin
                            // NACK on a sent byte: abort through stop
                            n_ack   = 1'b0;
                            n_state = ST_STOP_LO;
                        end else if (!n_is_read && c_step >= STEP_THIRD) begin
                            n_state = ST_STOP_LO;
                        end else if (n_is_read && c_step == STEP_SUB) begin
                            n_step  = STEP_SEC;
                            n_state = ST_RS_LO;
                        end else if (n_is_read && c_step >= STEP_LAST) begin
                            n_rx    = {c_shift, c_rx[7:0]};
                            n_state = ST_STOP_LO;
                        end else begin
                            // Next byte; the first received byte goes to the low half
                            if (n_is_read && c_step == STEP_THIRD) begin
                                n_rx = {8'd0, c_shift};
                            end
                            n_step  = c_step + 3'd1;
                            n_shift = f_byte(n_step, n_is_read, n_addr, n_reg, n_data);
                            n_bit   = 4'd0;
                            n_state = ST_BIT_LO;
                        end
                    end
                    ST_RS_LO:    n_state = ST_START_HI;
                    ST_STOP_LO:  n_state = ST_STOP_HI;
                    ST_STOP_HI:  n_state = ST_STOP_REL;
                    default: begin
                        n_out.done_res   = 1'b1;
                        n_out.nack_error = !c_ack;
                        n_out.rd_data    = (n_is_read && c_ack) ? c_rx : 16'd0;
                        n_state          = ST_IDLE;
                    end
                endcase
            end
        end
    end

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_half <= i_cfg_data;
        end
    end

    // Sequencer state, advanced once per input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= 16'd0;
            r_bit     <= 4'd0;
            r_step    <= STEP_ADDR;
            r_shift   <= 8'd0;
            r_addr    <= 8'd0;
            r_reg     <= 8'd0;
            r_data    <= 16'd0;
            r_rx      <= 16'd0;
            r_ack     <= 1'b0;
            r_is_read <= 1'b0;
        end else if (in_fire) begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_step    <= n_step;
            r_shift   <= n_shift;
            r_addr    <= n_addr;
            r_reg     <= n_reg;
            r_data    <= n_data;
            r_rx      <= n_rx;
            r_ack     <= n_ack;
            r_is_read <= n_is_read;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    // Checks
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= BITS_PER_BYTE)
        else $error("bit counter past acknowledge slot");

    a_step_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_is_read && r_state != ST_IDLE) |-> (r_step <= STEP_THIRD))
        else $error("write transaction past its last byte");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_phase == 16'd0))
        else $error("phase timer running while idle");

    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.nack_error) |-> (r_out.done_res && r_out.rd_data == 16'd0))
        else $error("error flag without done or with read data");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_out.done_res) |=> (r_state == ST_IDLE))
        else $error("sequencer not idle after done");

endmodule

@@ tb/tb_i2c_master_reg16_access_top.sv @@
// Self-checking testbench for the 16-bit register I2C master: predicts every tick of bus output.
module tb_i2c_master_reg16_access_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm16_pkg::*;

    // Op code the block treats as a plain tick
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Acknowledge slot selection for the bus responder
    localparam int NACK_NONE = -1;
    localparam int NACK_RAND = -2;

    localparam int RAND_BEATS = 450;

    // What the responder has to answer on the next tick
    typedef enum {PT_NONE, PT_ACK, PT_RX} t_probe;
    // Fill pattern for bytes read from the slave
    typedef enum {RX_ZEROS, RX_ONES, RX_RAND} t_rx_fill;

    // Tick-accurate model of the sequencer plus the queue of expected output beats
    class tick_scoreboard;
        t_out_item   expected_ticks[$];
        int          fails;
        logic [15:0] half_cfg;
        t_seq_state  st;
        logic [15:0] ph;
        logic [3:0]  bits;
        logic [2:0]  step;
        logic [7:0]  shreg;
        logic [7:0]  addr_l;
        logic [7:0]  reg_l;
        logic [15:0] data_l;
        logic [15:0] rx_word;
        logic        acked;
        logic        rd_mode;

        function new();
            fails    = 0;
            half_cfg = HALF_PERIOD_RESET;
            st       = ST_IDLE;
            ph       = '0;
            bits     = '0;
            step     = STEP_ADDR;
            shreg    = '0;
            addr_l   = '0;
            reg_l    = '0;
            data_l   = '0;
            rx_word  = '0;
            acked    = 1'b0;
            rd_mode  = 1'b0;
        endfunction

        function void set_half_period(logic [15:0] v);
            half_cfg = v;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        function bit seq_idle();
            return st == ST_IDLE;
        endfunction

        // zero acts as a one-tick phase
        function int eff_half();
            return (half_cfg == 16'd0) ? 1 : int'(half_cfg);
        endfunction

        function bit rx_phase();
            return rd_mode && (step >= STEP_THIRD);
        endfunction

        function logic [7:0] byte_to_send();
            logic [15:0] inv;
            inv = ~data_l;
            case (step)
                STEP_ADDR:  return addr_l;
                STEP_SUB:   return rd_mode ? 8'h00 : reg_l;
                STEP_SEC:   return rd_mode ? addr_l + 8'd1 : inv[7:0];
                STEP_THIRD: return rd_mode ? 8'h00 : inv[15:8];
                default:    return 8'h00;
            endcase
        endfunction

        function void load_byte();
            shreg = byte_to_send();
            bits  = '0;
            st    = ST_BIT_LO;
        endfunction

        // SDA level during a bit: data, released while receiving, master ACK/NACK
        function logic sda_level();
            if (bits < BITS_PER_BYTE)
                return rx_phase() ? 1'b1 : shreg[7];
            if (rx_phase())
                return (step == STEP_THIRD) ? 1'b0 : 1'b1;
            return 1'b1;
        endfunction

        // End of the acknowledge slot: pick the next byte or go to stop
        function void close_ack(logic sda);
            if (!rx_phase() && sda) begin
                acked = 1'b0;
                st    = ST_STOP_LO;
                return;
            end
            if (!rd_mode) begin
                if (step >= STEP_THIRD) begin
                    st = ST_STOP_LO;
                end else begin
                    step = step + 3'd1;
                    load_byte();
                end
                return;
            end
            case (step)
                STEP_ADDR: begin
                    step = STEP_SUB;
                    load_byte();
                end
                STEP_SUB: begin
                    step = STEP_SEC;
                    st   = ST_RS_LO;
                end
                STEP_SEC: begin
                    step = STEP_THIRD;
                    load_byte();
                end
                STEP_THIRD: begin
                    rx_word = {8'h00, shreg};
                    step    = STEP_LAST;
                    load_byte();
                end
                default: begin
                    rx_word = {shreg, rx_word[7:0]};
                    st      = ST_STOP_LO;
                end
            endcase
        endfunction

        // Is the coming tick one where the block samples SDA?
        function t_probe probe();
            if (st != ST_BIT_HI || int'(ph) + 1 < eff_half())
                return PT_NONE;
            if (bits < BITS_PER_BYTE)
                return rx_phase() ? PT_RX : PT_NONE;
            return rx_phase() ? PT_NONE : PT_ACK;
        endfunction

        function t_out_item predict_tick(t_in_item b);
            t_out_item o;
            o           = '0;
            o.scl_drive = 1'b1;
            o.sda_drive = 1'b1;
            if (st == ST_IDLE) begin
                if (b.op != OP_WRITE && b.op != OP_READ)
                    return o;
                addr_l  = b.dev_addr;
                reg_l   = b.reg_index;
                data_l  = b.wr_data;
                rd_mode = (b.op == OP_READ);
                st      = ST_START_HI;
                ph      = '0;
                bits    = '0;
                step    = STEP_ADDR;
                shreg   = '0;
                rx_word = '0;
                acked   = 1'b1;
            end
            o.busy_res = 1'b1;

            // bus levels of the current phase
            case (st)
                ST_START_HI: begin o.scl_drive = 1'b1; o.sda_drive = 1'b1;        end
                ST_START_LO: begin o.scl_drive = 1'b1; o.sda_drive = 1'b0;        end
                ST_BIT_LO:   begin o.scl_drive = 1'b0; o.sda_drive = sda_level(); end
                ST_BIT_HI:   begin o.scl_drive = 1'b1; o.sda_drive = sda_level(); end
                ST_RS_LO:    begin o.scl_drive = 1'b0; o.sda_drive = 1'b1;        end
                ST_STOP_LO:  begin o.scl_drive = 1'b0; o.sda_drive = 1'b0;        end
                ST_STOP_HI:  begin o.scl_drive = 1'b1; o.sda_drive = 1'b0;        end
                default:     begin o.scl_drive = 1'b1; o.sda_drive = 1'b1;        end
            endcase

            // phase timer and transitions on its last tick
            if (int'(ph) + 1 < eff_half()) begin
                ph = ph + 16'd1;
            end else begin
                ph = '0;
                case (st)
                    ST_START_HI: st = ST_START_LO;
                    ST_START_LO: load_byte();
                    ST_BIT_LO:   st = ST_BIT_HI;
                    ST_BIT_HI: begin
                        if (bits < BITS_PER_BYTE) begin
                            shreg = {shreg[6:0], rx_phase() ? b.sda_sample : 1'b0};
                            bits  = bits + 4'd1;
                            st    = ST_BIT_LO;
                        end else begin
                            close_ack(b.sda_sample);
                        end
                    end
                    ST_RS_LO:    st = ST_START_HI;
                    ST_STOP_LO:  st = ST_STOP_HI;
                    ST_STOP_HI:  st = ST_STOP_REL;
                    default: begin
                        o.done_res   = 1'b1;
                        o.nack_error = !acked;
                        o.rd_data    = (rd_mode && acked) ? rx_word : 16'h0000;
                        st           = ST_IDLE;
                    end
                endcase
            end
            return o;
        endfunction

        function void note_input(t_in_item b);
            expected_ticks.push_back(predict_tick(b));
        endfunction

        function void cmp_field(string name, int unsigned e, int unsigned a);
            if (e != a) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
                fails++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (expected_ticks.size() == 0) begin
                $error("output beat with nothing expected: 0x%0h", got);
                fails++;
                return;
            end
            e = expected_ticks.pop_front();
            cmp_field("scl_drive",  e.scl_drive,  got.scl_drive);
            cmp_field("sda_drive",  e.sda_drive,  got.sda_drive);
            cmp_field("busy_res",   e.busy_res,   got.busy_res);
            cmp_field("done_res",   e.done_res,   got.done_res);
            cmp_field("nack_error", e.nack_error, got.nack_error);
            cmp_field("rd_data",    e.rd_data,    got.rd_data);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    tick_scoreboard sb;
    int             beat_count = 0;
    bit             in_calm    = 1'b0;

    i2c_master_reg16_access_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Random beat: any op, any fields; ops are ignored while busy
    function automatic t_in_item rand_beat();
        t_in_item b;
        b.op         = 2'($urandom_range(0, 3));
        b.dev_addr   = 8'($urandom);
        b.reg_index  = 8'($urandom);
        b.wr_data    = 16'($urandom);
        b.sda_sample = 1'($urandom_range(0, 1));
        return b;
    endfunction

    // One input beat, after a random gap; valid stays high on return
    task automatic send_beat(input t_in_item b);
        int gap;
        if ($urandom_range(0, 39) == 0)
            in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_data  <= b;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(b);
        beat_count++;
    endtask

    // Idle ticks with the two non-starting op codes
    task automatic send_idle(input int n);
        t_in_item b;
        for (int i = 0; i < n; i++) begin
            b    = rand_beat();
            b.op = $urandom_range(0, 1) ? OP_TICK : OP_UNUSED;
            send_beat(b);
        end
    endtask

    // Phase length write; only once the sequencer is idle and all beats are out
    task automatic write_half_period(input logic [15:0] v);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_half_period(v);
    endtask

    // Start a transaction and keep ticking, answering as the slave, until it ends or max_ticks runs out
    task automatic run_txn(input logic [1:0] op, input logic [7:0] addr,
                           input logic [7:0] sub, input logic [15:0] data,
                           input int nack_slot, input t_rx_fill rx_fill,
                           input int max_ticks);
        t_in_item b;
        int       slot;
        int       ticks;
        slot        = 0;
        ticks       = 0;
        b           = rand_beat();
        b.op        = op;
        b.dev_addr  = addr;
        b.reg_index = sub;
        b.wr_data   = data;
        send_beat(b);
        while (!sb.seq_idle() && ticks < max_ticks) begin
            b = rand_beat();
            case (sb.probe())
                PT_ACK: begin
                    b.sda_sample = (slot == nack_slot) ||
                                   (nack_slot == NACK_RAND && $urandom_range(0, 11) == 0);
                    slot++;
                end
                PT_RX: begin
                    if (rx_fill == RX_RAND)
                        b.sda_sample = 1'($urandom_range(0, 1));
                    else
                        b.sda_sample = (rx_fill == RX_ONES);
                end
                default: ;
            endcase
            send_beat(b);
            ticks++;
        end
    endtask

    // Result side: random stalls, check every accepted beat
    initial begin
        int stall;
        bit out_calm;
        out_calm = 1'b0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                out_calm = !out_calm;
            stall = out_calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_result(o_out_data);
        end
    end

    // Stimulus
    initial begin
        int rand_base;
        int n_txn;
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset phase length: idle ticks, write refused at the address byte
        send_idle(3);
        run_txn(OP_WRITE, 8'hA4, 8'h12, 16'h5A5A, 0, RX_RAND, 1 << 30);

        // zero phase length acts as one tick
        write_half_period(16'h0000);
        run_txn(OP_WRITE, 8'hFF, 8'hFF, 16'h0000, NACK_NONE, RX_RAND, 1 << 30);
        run_txn(OP_WRITE, 8'h00, 8'h00, 16'hFFFF, NACK_NONE, RX_RAND, 1 << 30);
        // read with address wrap, all-ones word
        run_txn(OP_READ, 8'hFF, 8'h00, 16'h0000, NACK_NONE, RX_ONES, 1 << 30);
        run_txn(OP_READ, 8'h00, 8'hFF, 16'hFFFF, NACK_NONE, RX_ZEROS, 1 << 30);
        send_idle(2);

        // refusals at later bytes
        write_half_period(16'h0001);
        run_txn(OP_WRITE, 8'h40, 8'h06, 16'h1234, 3, RX_RAND, 1 << 30);
        run_txn(OP_READ, 8'h40, 8'h00, 16'h0000, 2, RX_RAND, 1 << 30);
        run_txn(OP_READ, 8'h40, 8'h00, 16'h0000, 1, RX_RAND, 1 << 30);

        // random transactions, with occasional refusals, over several phase lengths
        rand_base = beat_count;
        n_txn     = 0;
        while (beat_count - rand_base < RAND_BEATS) begin
            if (n_txn % 3 == 0) begin
                case ($urandom_range(0, 5))
                    0, 1, 5: write_half_period(16'd1);
                    2:       write_half_period(16'd2);
                    3:       write_half_period(16'd0);
                    default: write_half_period(16'd3);
                endcase
            end
            send_idle($urandom_range(0, 3));
            run_txn($urandom_range(0, 1) ? OP_READ : OP_WRITE, 8'($urandom), 8'($urandom),
                    16'($urandom), NACK_RAND, RX_RAND, 1 << 30);
            n_txn++;
        end

        // longest phase: the transaction only gets under way
        write_half_period(16'hFFFF);
        run_txn(OP_WRITE, 8'($urandom), 8'($urandom), 16'($urandom), NACK_NONE, RX_RAND, 80);
        i_in_valid <= 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ i2c_master_reg16_access_top.f @@
rtl/i2cm16_pkg.sv
rtl/i2c_master_reg16_access_top.sv
tb/tb_i2c_master_reg16_access_top.sv
